>>> hdl/twai_pkg.sv
// ----------------------------------------------------------------------------
// twai_pkg
// Shared types and constants of the touch wheel angle interpolator.
// ----------------------------------------------------------------------------
package twai_pkg;

	// wheel geometry and field widths
	localparam int SEGMENTS = 6;
	localparam int SAMPLE_W = 22;
	localparam int BASE_W   = 23;
	localparam int DIFF_W   = 24;
	localparam int MAG_W    = 23;
	localparam int THR_W    = 22;
	localparam int OFF_W    = 10;
	localparam int ANG_W    = 10;
	localparam int SECT_W   = 5;
	localparam int IDX_W    = 3;

	// configuration register indexes (baselines sit at 0 .. SEGMENTS-1)
	localparam logic [IDX_W-1:0] REG_THRESH = 3'd6;
	localparam logic [IDX_W-1:0] REG_OFFSET = 3'd7;

	localparam logic [THR_W-1:0] THRESH_RESET = 22'd1000;

	// segment indexes with a special meaning for the wrap pair
	localparam logic [IDX_W-1:0] SEG_FIRST = 3'd0;
	localparam logic [IDX_W-1:0] SEG_LAST  = 3'd5;

	// item classes decided by the front end
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_SINGLE = 2'd1;
	localparam logic [1:0] KIND_PAIR   = 2'd2;

	// floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT for x < 2**24
	localparam logic [24:0] RECIP_1000  = 25'd17179870;
	localparam int          RECIP_SHIFT = 34;

	// floor(a / 30) = (a * SECT_RECIP) >> SECT_SHIFT for a < 360
	localparam logic [9:0] SECT_RECIP = 10'd547;
	localparam int         SECT_SHIFT = 14;

	// angle constants, degrees and degrees with 8 fraction bits
	localparam logic [8:0]  SEG_DEG     = 9'd60;
	localparam logic [8:0]  WRAP_DEG    = 9'd300;
	localparam logic [10:0] FULL_DEG    = 11'd360;
	localparam logic [15:0] SEG_DEG_FX  = 16'd15360;
	localparam logic [15:0] HALF_DEG_FX = 16'd7680;

	typedef logic signed [BASE_W-1:0] base_t;

	// one classified frame handed from the front end to the back end
	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] big;
		logic [IDX_W-1:0] sec;
		logic [MAG_W-1:0] d_big;
		logic [MAG_W-1:0] d_sec;
	} item_t;

endpackage

>>> hdl/twai_regs.sv
// ----------------------------------------------------------------------------
// twai_regs
// Configuration registers behind a small APB-style slave port.
// ----------------------------------------------------------------------------
module twai_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [4:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output twai_pkg::base_t                   baseline [twai_pkg::SEGMENTS],
	output logic [twai_pkg::THR_W-1:0]        threshold,
	output logic signed [twai_pkg::OFF_W-1:0] offset
);
	import twai_pkg::*;

	base_t                    baseline_q [SEGMENTS];
	logic [THR_W-1:0]         thresh_q;
	logic signed [OFF_W-1:0]  offset_q;
	logic [IDX_W-1:0]         idx;
	logic                     wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SEGMENTS; i++) begin
				baseline_q[i] <= '0;
			end
			thresh_q <= THRESH_RESET;
			offset_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_THRESH: thresh_q <= pwdata[THR_W-1:0];
				REG_OFFSET: offset_q <= pwdata[OFF_W-1:0];
				default:    baseline_q[idx] <= pwdata[BASE_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_THRESH: prdata = {{(32-THR_W){1'b0}}, thresh_q};
			REG_OFFSET: prdata = {{(32-OFF_W){1'b0}}, offset_q};
			default:    prdata = {{(32-BASE_W){1'b0}}, baseline_q[idx]};
		endcase
	end

	assign baseline  = baseline_q;
	assign threshold = thresh_q;
	assign offset    = offset_q;

endmodule

>>> hdl/twai_front.sv
// ----------------------------------------------------------------------------
// twai_front
// Three-stage front end: baseline subtraction, pairwise compares and the
// pick of the strongest and second-strongest touched segment.
// ----------------------------------------------------------------------------
module twai_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [twai_pkg::SAMPLE_W-1:0]        sample [twai_pkg::SEGMENTS],
	input  twai_pkg::base_t                      baseline [twai_pkg::SEGMENTS],
	input  logic [twai_pkg::THR_W-1:0]           threshold,
	input  logic                                 q_full,
	output logic                                 q_push,
	output twai_pkg::item_t                      q_item
);
	import twai_pkg::*;

	logic                      adv;
	logic                      v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0]  diff_s1 [SEGMENTS];
	logic [SEGMENTS-1:0]       kept_s2;
	logic [MAG_W-1:0]          mag_s2 [SEGMENTS];
	logic [SEGMENTS-1:0]       gt_s2 [SEGMENTS];
	item_t                     item_s3;

	logic [SEGMENTS-1:0]       big_oh, sec_oh;
	item_t                     item_d;

	// the whole pipe moves unless the last stage cannot enter the queue
	assign adv    = !v_s3 || !q_full;
	assign full   = !adv;
	assign q_push = v_s3 && !q_full;
	assign q_item = item_s3;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: difference against baseline
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < SEGMENTS; i++) begin
				diff_s1[i] <= $signed({2'b00, sample[i]}) -
					$signed({baseline[i][BASE_W-1], baseline[i]});
			end
		end
	end

	// stage 2: threshold test and all pairwise compares
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < SEGMENTS; i++) begin
				kept_s2[i] <= diff_s1[i] > $signed({2'b00, threshold});
				mag_s2[i]  <= diff_s1[i][MAG_W-1:0];
				for (int j = 0; j < SEGMENTS; j++) begin
					gt_s2[i][j] <= diff_s1[i] > diff_s1[j];
				end
			end
		end
	end

	// strongest: first maximum; second: first maximum of the rest
	always_comb begin
		logic win;
		for (int i = 0; i < SEGMENTS; i++) begin
			win = kept_s2[i];
			for (int j = 0; j < SEGMENTS; j++) begin
				if (j != i && kept_s2[j]) begin
					if (j < i) win = win && gt_s2[i][j];
					else       win = win && !gt_s2[j][i];
				end
			end
			big_oh[i] = win;
		end
		for (int i = 0; i < SEGMENTS; i++) begin
			win = kept_s2[i] && !big_oh[i];
			for (int j = 0; j < SEGMENTS; j++) begin
				if (j != i && kept_s2[j] && !big_oh[j]) begin
					if (j < i) win = win && gt_s2[i][j];
					else       win = win && !gt_s2[j][i];
				end
			end
			sec_oh[i] = win;
		end
	end

	// encode the picks and classify the frame
	always_comb begin
		item_d = '0;
		for (int i = 0; i < SEGMENTS; i++) begin
			if (big_oh[i]) begin
				item_d.big   = item_d.big | IDX_W'(i);
				item_d.d_big = item_d.d_big | mag_s2[i];
			end
			if (sec_oh[i]) begin
				item_d.sec   = item_d.sec | IDX_W'(i);
				item_d.d_sec = item_d.d_sec | mag_s2[i];
			end
		end
		if (|sec_oh)      item_d.kind = KIND_PAIR;
		else if (|big_oh) item_d.kind = KIND_SINGLE;
		else              item_d.kind = KIND_NONE;
	end

	// stage 3: classified item waiting for the queue
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3 <= item_d;
		end
	end

endmodule

>>> hdl/twai_queue.sv
// ----------------------------------------------------------------------------
// twai_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module twai_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  twai_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output twai_pkg::item_t rd_item,
	output logic            empty
);
	import twai_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> hdl/twai_back.sv
// ----------------------------------------------------------------------------
// twai_back
// Back end sequencer: a pair is scaled down by 1000, divided for the ratio
// and folded into place; touched angles wrap with the offset, results held.
// ----------------------------------------------------------------------------
module twai_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  twai_pkg::item_t                     q_item,
	output logic                                q_pop,
	input  logic signed [twai_pkg::OFF_W-1:0]   offset,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [twai_pkg::ANG_W-1:0]   wheel_angle,
	output logic                                is_touched,
	output logic signed [twai_pkg::SECT_W-1:0]  sector
);
	import twai_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SCALE_S = 4'd1;
	localparam logic [3:0] ST_SCALE_P = 4'd2;
	localparam logic [3:0] ST_DIV     = 4'd3;
	localparam logic [3:0] ST_MUL60   = 4'd4;
	localparam logic [3:0] ST_FOLD    = 4'd5;
	localparam logic [3:0] ST_WRAP_A  = 4'd6;
	localparam logic [3:0] ST_WRAP_B  = 4'd7;
	localparam logic [3:0] ST_DONE    = 4'd8;

	localparam logic [3:0] DIV_LAST = 4'd8;

	logic [3:0]               state_q;
	logic [3:0]               cnt_q;
	logic                     none_q;
	logic [IDX_W-1:0]         big_q, sec_q;
	logic [MAG_W-1:0]         dbig_q;
	logic [23:0]              sum_q;
	logic [14:0]              s_q;
	logic [14:0]              rem_q;
	logic [8:0]               quot_q;
	logic [15:0]              d_q;
	logic [8:0]               deg_q;
	logic signed [10:0]       wrp_q;
	logic [8:0]               ang_q;

	logic                     out_v_q;
	logic signed [ANG_W-1:0]  angle_q;
	logic                     touched_q;
	logic signed [SECT_W-1:0] sector_q;

	logic [23:0]              mul_a;
	logic [48:0]              mul_p;
	logic [15:0]              trial;
	logic                     ge;
	logic [8:0]               fold_deg;
	logic signed [10:0]       wrap_a;
	logic signed [10:0]       wrap_b;
	logic [18:0]              sect_p;
	logic                     out_free;

	// one step toward 0..359
	function automatic logic signed [10:0] wrap_step(input logic signed [10:0] v);
		logic signed [10:0] r;
		if (v < 0)                      r = v + $signed(FULL_DEG);
		else if (v >= $signed(FULL_DEG)) r = v - $signed(FULL_DEG);
		else                            r = v;
		return r;
	endfunction

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !out_v_q || pop;

	// shared reciprocal multiplier for the two divisions by 1000
	assign mul_a = (state_q == ST_SCALE_S) ? sum_q : {1'b0, dbig_q};
	assign mul_p = mul_a * RECIP_1000;

	// restoring divide step; first step takes the integer bit
	assign trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign ge    = trial >= {1'b0, s_q};

	// mirror, wrap from zero and segment base
	always_comb begin
		logic              mirror, wrap0, pairw;
		logic signed [15:0] t;
		logic [15:0]       mag;
		logic [15:0]       stp;
		logic [15:0]       d1, d2;
		logic [IDX_W-1:0]  lo;
		mirror = (big_q < sec_q) || (big_q == SEG_LAST && sec_q == SEG_FIRST);
		wrap0  = (big_q == SEG_FIRST) && (sec_q == SEG_LAST);
		pairw  = wrap0 || (big_q == SEG_LAST && sec_q == SEG_FIRST);
		lo     = (big_q < sec_q) ? big_q : sec_q;
		t      = $signed(d_q) - $signed(HALF_DEG_FX);
		mag    = (t < 0) ? 16'(-t) : 16'(t);
		stp    = {mag[15:8], 8'd0} << 1;
		if (!mirror)    d1 = d_q;
		else if (t < 0) d1 = d_q + stp;
		else            d1 = d_q - stp;
		d2 = wrap0 ? (SEG_DEG_FX - d1) : d1;
		fold_deg = {1'b0, d2[15:8]} + 9'(9'(lo) * SEG_DEG) + (pairw ? WRAP_DEG : 9'd0);
	end

	assign wrap_a = wrap_step($signed({2'b00, deg_q}) + $signed({offset[OFF_W-1], offset}));
	assign wrap_b = wrap_step(wrp_q);
	assign sect_p = {1'b0, ang_q} * SECT_RECIP;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						case (q_item.kind)
							KIND_PAIR:   state_q <= ST_SCALE_S;
							KIND_SINGLE: state_q <= ST_WRAP_A;
							default:     state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCALE_S: state_q <= ST_SCALE_P;
				ST_SCALE_P: begin
					cnt_q   <= '0;
					state_q <= (s_q == '0) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_MUL60;
					end
				end
				ST_MUL60:  state_q <= ST_FOLD;
				ST_FOLD:   state_q <= ST_WRAP_A;
				ST_WRAP_A: state_q <= ST_WRAP_B;
				ST_WRAP_B: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				big_q  <= q_item.big;
				sec_q  <= q_item.sec;
				dbig_q <= q_item.d_big;
				sum_q  <= {1'b0, q_item.d_big} + {1'b0, q_item.d_sec};
				deg_q  <= 9'(9'(q_item.big) * SEG_DEG);
				none_q <= q_item.kind == KIND_NONE;
			end
			ST_SCALE_S: s_q <= mul_p[RECIP_SHIFT +: 15];
			ST_SCALE_P: begin
				rem_q  <= mul_p[RECIP_SHIFT +: 15];
				quot_q <= '0;
				none_q <= s_q == '0;
			end
			ST_DIV: begin
				rem_q  <= ge ? 15'(trial - {1'b0, s_q}) : trial[14:0];
				quot_q <= {quot_q[7:0], ge};
			end
			ST_MUL60:  d_q   <= {7'd0, quot_q} * {7'd0, SEG_DEG};
			ST_FOLD:   deg_q <= fold_deg;
			ST_WRAP_A: wrp_q <= wrap_a;
			ST_WRAP_B: ang_q <= wrap_b[8:0];
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			if (none_q) begin
				angle_q   <= '1;
				touched_q <= 1'b0;
				sector_q  <= '1;
			end else begin
				angle_q   <= $signed({1'b0, ang_q});
				touched_q <= 1'b1;
				sector_q  <= $signed(sect_p[SECT_SHIFT +: SECT_W]);
			end
		end
	end

	assign empty       = !out_v_q;
	assign wheel_angle = angle_q;
	assign is_touched  = touched_q;
	assign sector      = sector_q;

endmodule

>>> hdl/touch_wheel_angle_interpolator.sv
// ----------------------------------------------------------------------------
// touch_wheel_angle_interpolator
// Turns a frame of six capacitive wheel readings into an angle and sector.
// ----------------------------------------------------------------------------
// A three-stage front end takes one frame per cycle while full is low,
// subtracts baselines, applies the threshold and picks the two strongest
// segments; frames then wait in a queue of QUEUE_DEPTH entries for the back
// end, a sequencer that works one frame at a time. A two-segment frame goes
// through two reciprocal multiplies, a 9-step restoring divide, the fold and
// two wrap steps, a one-segment frame through the two wrap steps only and an
// untouched frame straight to the result register, so the divide loop sets
// the sustained rate. One result comes out for every frame, in order, through
// a one-entry result register.
module touch_wheel_angle_interpolator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [4:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                push,
	output logic                                full,
	input  logic [twai_pkg::SAMPLE_W-1:0]       sample_seg0,
	input  logic [twai_pkg::SAMPLE_W-1:0]       sample_seg1,
	input  logic [twai_pkg::SAMPLE_W-1:0]       sample_seg2,
	input  logic [twai_pkg::SAMPLE_W-1:0]       sample_seg3,
	input  logic [twai_pkg::SAMPLE_W-1:0]       sample_seg4,
	input  logic [twai_pkg::SAMPLE_W-1:0]       sample_seg5,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [twai_pkg::ANG_W-1:0]   wheel_angle,
	output logic                                is_touched,
	output logic signed [twai_pkg::SECT_W-1:0]  sector
);
	import twai_pkg::*;

	logic [SAMPLE_W-1:0]     sample [SEGMENTS];
	base_t                   baseline [SEGMENTS];
	logic [THR_W-1:0]        threshold;
	logic signed [OFF_W-1:0] offset;
	logic                    q_full, q_push, q_empty, q_pop;
	item_t                   q_wr_item, q_rd_item;

	assign sample[0] = sample_seg0;
	assign sample[1] = sample_seg1;
	assign sample[2] = sample_seg2;
	assign sample[3] = sample_seg3;
	assign sample[4] = sample_seg4;
	assign sample[5] = sample_seg5;

	// configuration registers
	twai_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.baseline  (baseline),
		.threshold (threshold),
		.offset    (offset)
	);

	// front end: classify each frame
	twai_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.baseline  (baseline),
		.threshold (threshold),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_wr_item)
	);

	// decoupling queue
	twai_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.full    (q_full),
		.pop     (q_pop),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	// back end: angle arithmetic and result register
	twai_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (q_rd_item),
		.q_pop       (q_pop),
		.offset      (offset),
		.empty       (empty),
		.pop         (pop),
		.wheel_angle (wheel_angle),
		.is_touched  (is_touched),
		.sector      (sector)
	);

endmodule
